// ===== rtl/core/rve_pkg.sv =====
// ----------------------------------------------------------------------------
// rve_pkg
// Shared types and constants of the register machine executor: field widths,
// action codes, decoded operation format and queue sizing.
// ----------------------------------------------------------------------------
package rve_pkg;

  // machine registers
  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_AW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned REGNUM_W  = 8;

  // stream beat widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned IN_FIELDS_W  = ACT_W + 2 * REGNUM_W + DATA_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 2 + DATA_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // decoded-op queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // divider step counter
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

  // raw action codes on the input stream
  typedef enum logic [ACT_W-1:0] {
    ACT_NOP   = 3'd0,
    ACT_LDI   = 3'd1,
    ACT_ADD   = 3'd2,
    ACT_SUB   = 3'd3,
    ACT_MUL   = 3'd4,
    ACT_DIV   = 3'd5,
    ACT_HALT  = 3'd6,
    ACT_UNSUP = 3'd7
  } action_e;

  // decoded operations handed to the back end
  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_LDI  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_HALT = 3'd6
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              d_ok;
    logic [REG_AW-1:0] d_idx;
    logic [REG_AW-1:0] s_idx;
    logic [DATA_W-1:0] imm;
  } op_t;

  // queue status seen by the back end
  typedef struct packed {
    logic vld;
    op_t  head;
  } q_stat_t;

endpackage

// ===== rtl/core/register_vm_executor_unit.sv =====
// ----------------------------------------------------------------------------
// register_vm_executor_unit
// Flow: a beat enters the decoded-op queue; the back end pops it when idle,
// executes it (iterating in the divider for a nonzero divisor) and then waits
// for a free output slot. It works on one item at a time while the queue still
// takes beats until full; the divider retires one quotient bit per cycle.
// Reset: registers read as zero and the machine is running; no clearing pass.
// ----------------------------------------------------------------------------
module register_vm_executor_unit import rve_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // action, dest_reg, source_reg, immediate
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // halted_flag, wrote, dest_value
);

  logic    q_full;
  logic    push;
  op_t     push_op;
  logic    pop;
  q_stat_t q_stat;

  // decode and classify
  rve_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_op_o       (push_op)
  );

  // decoupling queue
  rve_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .full_o    (q_full),
    .stat_o    (q_stat)
  );

  // execute and report
  rve_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== rtl/core/rve_front.sv =====
// ----------------------------------------------------------------------------
// rve_front
// Input side: unpacks a beat, range-checks register numbers and classifies
// the action into a decoded op that is pushed into the queue.
// ----------------------------------------------------------------------------
module rve_front import rve_pkg::*; (
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,  // action, dest_reg, source_reg, immediate
  input  logic                  q_full_i,
  output logic                  push_o,
  output op_t                   push_op_o
);

  logic [ACT_W-1:0]    act;
  logic [REGNUM_W-1:0] dst;
  logic [REGNUM_W-1:0] src;
  logic                d_ok;
  logic                s_ok;
  logic                both_ok;

  assign act = s_axis_tdata_i[ACT_W-1:0];
  assign dst = s_axis_tdata_i[ACT_W +: REGNUM_W];
  assign src = s_axis_tdata_i[ACT_W+REGNUM_W +: REGNUM_W];

  // register numbers beyond the file are out of range
  assign d_ok    = {1'b0, dst} < (REGNUM_W+1)'(REG_COUNT);
  assign s_ok    = {1'b0, src} < (REGNUM_W+1)'(REG_COUNT);
  assign both_ok = d_ok && s_ok;

  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

  // classify: ops with bad operands collapse to a no-op
  always_comb begin
    push_op_o.d_ok  = d_ok;
    push_op_o.d_idx = dst[REG_AW-1:0];
    push_op_o.s_idx = src[REG_AW-1:0];
    push_op_o.imm   = s_axis_tdata_i[ACT_W+2*REGNUM_W +: DATA_W];
    unique case (action_e'(act))
      ACT_NOP:   push_op_o.op = OP_NOP;
      ACT_LDI:   push_op_o.op = d_ok    ? OP_LDI : OP_NOP;
      ACT_ADD:   push_op_o.op = both_ok ? OP_ADD : OP_NOP;
      ACT_SUB:   push_op_o.op = both_ok ? OP_SUB : OP_NOP;
      ACT_MUL:   push_op_o.op = both_ok ? OP_MUL : OP_NOP;
      ACT_DIV:   push_op_o.op = both_ok ? OP_DIV : OP_NOP;
      ACT_HALT:  push_op_o.op = OP_HALT;
      ACT_UNSUP: push_op_o.op = OP_HALT;
      default:   push_op_o.op = OP_HALT;
    endcase
  end

endmodule

// ===== rtl/core/rve_queue.sv =====
// ----------------------------------------------------------------------------
// rve_queue
// Small FIFO of decoded ops that decouples the front from the back end.
// ----------------------------------------------------------------------------
module rve_queue import rve_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  op_t     push_op_i,
  input  logic    pop_i,
  output logic    full_o,
  output q_stat_t stat_o
);

  op_t               mem_q [QDEPTH];
  logic [QAW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o      = cnt_q == QCNT_W'(QDEPTH);
  assign stat_o.vld  = cnt_q != '0;
  assign stat_o.head = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && stat_o.vld;

  // pointer and fill-level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== rtl/core/rve_back.sv =====
// ----------------------------------------------------------------------------
// rve_back
// Execution side: register file with registered reads, ALU, iterative
// restoring divider (one quotient bit per cycle) and the output register.
// ----------------------------------------------------------------------------
module rve_back import rve_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  q_stat_t                q_stat_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o  // halted_flag, wrote, dest_value
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  op_t                    op_q;
  logic [DATA_W-1:0]      rf_q [REG_COUNT];
  logic [REG_COUNT-1:0]   rf_vld_q, rf_vld_d;
  logic [DATA_W-1:0]      rd_a_q, rd_b_q;
  logic                   a_ok_q, b_ok_q;
  logic                   halted_q, halted_d;
  logic                   wr_q, wr_d;
  logic [DATA_W-1:0]      res_q, res_d;
  logic [DATA_W-1:0]      rem_q, rem_d;
  logic [DATA_W-1:0]      quo_q, quo_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic [DATA_W-1:0]      op_a, op_b;
  logic [DATA_W-1:0]      prod;
  logic [DATA_W:0]        rem_sh;
  logic                   rem_ge;
  logic [DATA_W-1:0]      rem_nxt, quo_nxt;
  logic                   slot_free;
  logic                   rf_we;

  // operands: never-written registers read as zero
  assign op_a = a_ok_q ? rd_a_q : '0;
  assign op_b = b_ok_q ? rd_b_q : '0;
  assign prod = op_a * op_b;

  // one restoring divide step
  assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, op_b};
  assign rem_nxt = rem_ge ? DATA_W'(rem_sh - {1'b0, op_b}) : rem_sh[DATA_W-1:0];
  assign quo_nxt = {quo_q[DATA_W-2:0], rem_ge};

  assign slot_free = !out_vld_q || m_axis_tready_i;
  assign pop_o     = (state_q == ST_IDLE) && q_stat_i.vld;
  assign rf_we     = (state_q == ST_DONE) && slot_free && wr_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    halted_d   = halted_q;
    wr_d       = wr_q;
    res_d      = res_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    rf_vld_d   = rf_vld_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_stat_i.vld) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        wr_d    = 1'b0;
        res_d   = op_a;
        state_d = ST_DONE;
        if (!halted_q) begin
          unique case (op_q.op)
            OP_NOP: ;
            OP_LDI: begin
              wr_d  = 1'b1;
              res_d = op_q.imm;
            end
            OP_ADD: begin
              wr_d  = 1'b1;
              res_d = op_a + op_b;
            end
            OP_SUB: begin
              wr_d  = 1'b1;
              res_d = op_a - op_b;
            end
            OP_MUL: begin
              wr_d  = 1'b1;
              res_d = prod;
            end
            OP_DIV: begin
              // zero divisor: skipped, no write
              if (op_b != '0) begin
                rem_d   = '0;
                quo_d   = op_a;
                cnt_d   = DIV_CNT_W'(DATA_W - 1);
                state_d = ST_DIV;
              end
            end
            OP_HALT: halted_d = 1'b1;
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        rem_d = rem_nxt;
        quo_d = quo_nxt;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          wr_d    = 1'b1;
          res_d   = quo_nxt;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          if (wr_q) begin
            rf_vld_d[op_q.d_idx] = 1'b1;
          end
          out_vld_d  = 1'b1;
          out_data_d = OUT_TDATA_W'({op_q.d_ok ? res_q : DATA_W'(0), wr_q, halted_q});
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      halted_q  <= 1'b0;
      wr_q      <= 1'b0;
      cnt_q     <= '0;
      rf_vld_q  <= '0;
      a_ok_q    <= 1'b0;
      b_ok_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      halted_q  <= halted_d;
      wr_q      <= wr_d;
      cnt_q     <= cnt_d;
      rf_vld_q  <= rf_vld_d;
      out_vld_q <= out_vld_d;
      if (pop_o) begin
        a_ok_q <= q_stat_i.head.d_ok && rf_vld_q[q_stat_i.head.d_idx];
        b_ok_q <= rf_vld_q[q_stat_i.head.s_idx];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
    if (pop_o) begin
      op_q <= q_stat_i.head;
    end
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[op_q.d_idx] <= res_q;
    end
    if (pop_o) begin
      rd_a_q <= rf_q[q_stat_i.head.d_idx];
      rd_b_q <= rf_q[q_stat_i.head.s_idx];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== rtl/core/rve_checker.sv =====
// ----------------------------------------------------------------------------
// rve_checker
// Port-level checks of the executor: output stall behavior, halt stickiness
// and register writes around a halt as seen on the result stream.
// ----------------------------------------------------------------------------
module rve_checker import rve_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // halted_flag, wrote, dest_value
);

  logic out_beat;
  logic seen_halt_q;

  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  // a halted flag has gone out on an earlier beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (out_beat && m_axis_tdata_o[0]) begin
      seen_halt_q <= 1'b1;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_halt_q |-> m_axis_tdata_o[0])
    else $error("halted flag cleared after halt");

  a_no_write_after_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_halt_q |-> !m_axis_tdata_o[1])
    else $error("register written after halt");

  // a halting item never writes, and a halted machine never writes
  a_write_not_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && m_axis_tdata_o[1] |-> !m_axis_tdata_o[0])
    else $error("write reported together with halt");

endmodule

bind register_vm_executor_unit rve_checker u_rve_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
